/* hdl/sqdist_pkg.sv */
// Package for the uint8 squared distance engine.
// Shared constants, action codes and the pipeline tag type.
// No dependencies.
package sqdist_pkg;

  // Field widths fixed by the item format
  localparam int BYTE_W    = 8;
  localparam int SQ_W      = 16;
  localparam int DATA_W    = 64;
  localparam int CFG_W     = 13;
  localparam int DIST_W    = 28;
  localparam int VNUM_W    = 16;
  localparam int OUT_W     = 48;

  localparam logic [CFG_W-1:0]  CFG_LEN_RESET = 13'd128;
  localparam logic [DIST_W-1:0] DIST_MAX      = 28'hFFFFFFF;

  // Result queue
  localparam int FIFO_DEPTH  = 8;
  localparam int FIFO_PTR_W  = 3;
  localparam int FIFO_CNT_W  = 4;

  // Input item kinds (in_tuser)
  localparam logic ACT_LOAD    = 1'b0;
  localparam logic ACT_COMPARE = 1'b1;

  // Control that rides along with a chunk through the pipeline
  typedef struct packed {
    logic valid;
    logic cmp;
    logic last;
  } sqdist_tag_t;

endpackage

/* hdl/sqdist_chunk.sv */
// Per-chunk squared difference unit: lane squares, then the chunk sum.
// Two register stages. Depends on sqdist_pkg.
module sqdist_chunk #(
  parameter int LANES = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  sqdist_pkg::sqdist_tag_t     tag_i,
  input  logic [LANES*8-1:0]          q_i,
  input  logic [LANES*8-1:0]          d_i,
  input  logic [LANES-1:0]            mask_i,
  output sqdist_pkg::sqdist_tag_t     tag_o,
  output logic [$clog2(LANES*65025+1)-1:0] sum_o
);

  localparam int SUM_W = $clog2(LANES*65025+1);

  logic [sqdist_pkg::SQ_W-1:0] sq_nxt [LANES];
  logic [sqdist_pkg::SQ_W-1:0] sq_r   [LANES];
  sqdist_pkg::sqdist_tag_t     tag2_r;
  sqdist_pkg::sqdist_tag_t     tag3_r;
  logic [SUM_W-1:0]            sum_nxt;
  logic [SUM_W-1:0]            sum_r;

  // Lane squares of the absolute byte difference; masked lanes give zero
  always_comb begin
    logic [sqdist_pkg::BYTE_W-1:0] a;
    logic [sqdist_pkg::BYTE_W-1:0] b;
    logic [sqdist_pkg::BYTE_W-1:0] ad;
    for (int l = 0; l < LANES; l++) begin
      a  = d_i[l*8 +: 8];
      b  = q_i[l*8 +: 8];
      ad = (a > b) ? (a - b) : (b - a);
      sq_nxt[l] = mask_i[l] ? (sqdist_pkg::SQ_W'(ad) * sqdist_pkg::SQ_W'(ad)) : '0;
    end
  end

  // Chunk sum over the lanes
  always_comb begin
    sum_nxt = '0;
    for (int l = 0; l < LANES; l++) begin
      sum_nxt = sum_nxt + SUM_W'(sq_r[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag2_r <= '0;
      tag3_r <= '0;
    end else begin
      tag2_r <= tag_i;
      tag3_r <= tag2_r;
    end
    sq_r  <= sq_nxt;
    sum_r <= sum_nxt;
  end

  assign tag_o = tag3_r;
  assign sum_o = sum_r;

endmodule

/* hdl/uint8_squared_distance_engine.sv */
// Top level of the uint8 squared distance engine: query store, chunk
// sequencing, accumulator and result queue. Depends on sqdist_pkg, sqdist_chunk.
//
// Usage:
//   Input stream (in_*): in_tuser selects the item kind (0 = load a query
//   chunk, 1 = compare a database chunk), in_tdata carries LANES bytes.
//   Load chunks fill the query store in order; compare chunks are scored
//   against the query chunk at the same position. After the last chunk of
//   a vector one result leaves on out_* with the distance and the vector
//   number (counted from the last query load).
//   Configuration: cfg_wr_en writes the vector length (elements); the user
//   must write it only while idle, as the block does not enforce this.
//   Throughput: one chunk per cycle while in_tready is high; the single query
//   store port takes one access per item. Result path: store read, lane
//   squares, chunk sum; the accumulate then writes the queue for out_tvalid.
//   Reset: counters, accumulator and result queue clear; the vector length
//   returns to 128. The query store is not cleared and must be loaded first.
//   Stall: results wait in an 8-entry queue; in_tready drops only when the
//   queue plus results still in the pipeline would fill it.
module uint8_squared_distance_engine #(
  parameter int MAX_LENGTH = 4096,
  parameter int LANES      = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [LANES*8-1:0]                  in_tdata,  // data_bytes
  input  logic                                in_tuser,  // action
  // Result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [sqdist_pkg::OUT_W-1:0]        out_tdata, // distance, vector_number, zero pad
  // Configuration
  input  logic                                cfg_wr_en,
  input  logic [sqdist_pkg::CFG_W-1:0]        cfg_wr_data
);

  localparam int CHUNK_W     = LANES * 8;
  localparam int STORE_DEPTH = (MAX_LENGTH + LANES - 1) / LANES;
  localparam int PTR_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int IDX_W       = $clog2(MAX_LENGTH + 2 * LANES);
  localparam int SUM_W       = $clog2(LANES * 65025 + 1);
  localparam int ACC_W       = $clog2(MAX_LENGTH * 65025 + 1);

  // Configuration and sequencing state
  logic [sqdist_pkg::CFG_W-1:0] cfg_len_r;
  logic [PTR_W-1:0]             chunk_cnt_r;
  logic [PTR_W-1:0]             chunk_cnt_nxt;
  logic [IDX_W-1:0]             len_eff;
  logic [IDX_W-1:0]             base_idx;
  logic                         is_last;
  logic [LANES-1:0]             lane_mask;
  logic                         in_xfer;
  logic                         out_xfer;

  // Query store
  logic [CHUNK_W-1:0]           qstore_mem [STORE_DEPTH];
  logic [CHUNK_W-1:0]           q1_r;

  // Stage registered with the store read
  sqdist_pkg::sqdist_tag_t      tag1_r;
  logic [CHUNK_W-1:0]           d1_r;
  logic [LANES-1:0]             mask1_r;

  // Chunk unit output
  sqdist_pkg::sqdist_tag_t      tag_s;
  logic [SUM_W-1:0]             sum_s;

  // Accumulator and vector counter
  logic [ACC_W-1:0]             acc_r;
  logic [ACC_W-1:0]             acc_sum;
  logic [31:0]                  acc_ext;
  logic [sqdist_pkg::DIST_W-1:0] dist_val;
  logic [sqdist_pkg::VNUM_W-1:0] vcnt_r;
  logic                         res_push;

  // Result queue
  logic [sqdist_pkg::OUT_W-1:0]      res_fifo_r [sqdist_pkg::FIFO_DEPTH];
  logic [sqdist_pkg::FIFO_PTR_W-1:0] wr_ptr_r;
  logic [sqdist_pkg::FIFO_PTR_W-1:0] rd_ptr_r;
  logic [sqdist_pkg::FIFO_CNT_W-1:0] fifo_cnt_r;
  logic [sqdist_pkg::FIFO_CNT_W-1:0] resv_r;
  logic                              resv_inc;

  // Handshakes
  assign in_tready = (resv_r < sqdist_pkg::FIFO_CNT_W'(sqdist_pkg::FIFO_DEPTH));
  assign in_xfer   = in_tvalid && in_tready;
  assign out_tvalid = (fifo_cnt_r != '0);
  assign out_xfer   = out_tvalid && out_tready;
  assign out_tdata  = res_fifo_r[rd_ptr_r];

  // Effective length: zero acts as one, clamp at MAX_LENGTH
  always_comb begin
    if (cfg_len_r == '0) begin
      len_eff = IDX_W'(1);
    end else if (32'(cfg_len_r) > 32'(MAX_LENGTH)) begin
      len_eff = IDX_W'(MAX_LENGTH);
    end else begin
      len_eff = IDX_W'(cfg_len_r);
    end
  end

  // Chunk position, last-chunk test and lane mask
  always_comb begin
    base_idx = IDX_W'(chunk_cnt_r) * IDX_W'(LANES);
    is_last  = ((base_idx + IDX_W'(LANES)) >= len_eff);
    for (int l = 0; l < LANES; l++) begin
      lane_mask[l] = ((base_idx + IDX_W'(l)) < len_eff);
    end
    chunk_cnt_nxt = is_last ? '0 : (chunk_cnt_r + PTR_W'(1));
  end

  // A compare on the last chunk reserves a queue slot
  assign resv_inc = in_xfer && (in_tuser == sqdist_pkg::ACT_COMPARE) && is_last;

  // Query store: write on load, registered read on compare
  always_ff @(posedge clk) begin
    if (in_xfer && (in_tuser == sqdist_pkg::ACT_LOAD)) begin
      qstore_mem[chunk_cnt_r] <= in_tdata;
    end
    if (in_xfer && (in_tuser == sqdist_pkg::ACT_COMPARE)) begin
      q1_r <= qstore_mem[chunk_cnt_r];
    end
  end

  // Accept stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_len_r   <= sqdist_pkg::CFG_LEN_RESET;
      chunk_cnt_r <= '0;
      tag1_r      <= '0;
    end else begin
      if (cfg_wr_en) begin
        cfg_len_r <= cfg_wr_data;
      end
      if (in_xfer) begin
        chunk_cnt_r <= chunk_cnt_nxt;
      end
      tag1_r.valid <= in_xfer;
      tag1_r.cmp   <= (in_tuser == sqdist_pkg::ACT_COMPARE);
      tag1_r.last  <= is_last;
    end
    d1_r    <= in_tdata;
    mask1_r <= lane_mask;
  end

  sqdist_chunk #(
    .LANES (LANES)
  ) u_chunk (
    .clk    (clk),
    .rst_n  (rst_n),
    .tag_i  (tag1_r),
    .q_i    (q1_r),
    .d_i    (d1_r),
    .mask_i (mask1_r),
    .tag_o  (tag_s),
    .sum_o  (sum_s)
  );

  // Accumulate and form the result
  always_comb begin
    acc_sum  = acc_r + ACC_W'(sum_s);
    acc_ext  = 32'(acc_sum);
    dist_val = (acc_ext > 32'(sqdist_pkg::DIST_MAX)) ? sqdist_pkg::DIST_MAX
                                                     : acc_ext[sqdist_pkg::DIST_W-1:0];
    res_push = tag_s.valid && tag_s.cmp && tag_s.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      vcnt_r <= '0;
    end else if (tag_s.valid) begin
      if (!tag_s.cmp) begin
        acc_r  <= '0;
        vcnt_r <= '0;
      end else if (tag_s.last) begin
        acc_r  <= '0;
        vcnt_r <= vcnt_r + sqdist_pkg::VNUM_W'(1);
      end else begin
        acc_r <= acc_sum;
      end
    end
  end

  // Result queue and slot reservation
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      fifo_cnt_r <= '0;
      resv_r     <= '0;
    end else begin
      if (res_push) begin
        wr_ptr_r <= wr_ptr_r + sqdist_pkg::FIFO_PTR_W'(1);
      end
      if (out_xfer) begin
        rd_ptr_r <= rd_ptr_r + sqdist_pkg::FIFO_PTR_W'(1);
      end
      fifo_cnt_r <= fifo_cnt_r + sqdist_pkg::FIFO_CNT_W'(res_push)
                               - sqdist_pkg::FIFO_CNT_W'(out_xfer);
      resv_r     <= resv_r + sqdist_pkg::FIFO_CNT_W'(resv_inc)
                           - sqdist_pkg::FIFO_CNT_W'(out_xfer);
    end
    if (res_push) begin
      res_fifo_r[wr_ptr_r] <= {4'b0000, vcnt_r, dist_val};
    end
  end

endmodule
